// ===== rtl/tt_pkg.sv =====
// Shared types, widths and codes for the transposition table probe/insert block.
// Depends on nothing; the top level, tt_eval and both testbench files import it.
`timescale 1ns / 1ps

package tt_pkg;

   localparam int TT_TABLE_ENTRIES = 4096;
   localparam int TT_TAG_BITS      = 32;

   localparam int SLOT_BITS       = 12;
   localparam int TAG_PORT_BITS   = 32;
   localparam int OCC_BITS        = 6;
   localparam int DEPTH_BITS      = 6;
   localparam int SCORE_BITS      = 8;
   localparam int CODE_BITS       = 6;
   localparam int KIND_BITS       = 2;
   localparam int SCORE_BASE_BITS = 7;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 7;
   localparam int META_BITS       = CODE_BITS + KIND_BITS + DEPTH_BITS;

   localparam logic [SCORE_BASE_BITS-1:0] SCORE_BASE_RESET  = 7'd43;
   localparam logic [DEPTH_BITS-1:0]      YIELD_DEPTH_RESET = 6'd63;
   localparam logic [CODE_BITS-1:0]       CODE_MAX          = 6'd63;

   typedef enum logic [1:0] {
      OP_PROBE  = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_NONE  = 2'd0,
      KIND_EXACT = 2'd1,
      KIND_LOWER = 2'd2,
      KIND_UPPER = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCORE_BASE  = 1'd0,
      CSR_YIELD_DEPTH = 1'd1
   } csr_index_type;

   // Non-tag part of a stored entry, most significant field first.
   typedef struct packed {
      logic [CODE_BITS-1:0]  code;
      kind_type              kind;
      logic [DEPTH_BITS-1:0] depth;
   } meta_type;

   typedef struct packed {
      logic [SCORE_BASE_BITS-1:0] score_base;
      logic [DEPTH_BITS-1:0]      yield_depth;
   } cfg_type;

   typedef struct packed {
      op_type                       op;
      logic [OCC_BITS-1:0]          occupied;
      logic [DEPTH_BITS-1:0]        depth;
      logic signed [SCORE_BITS-1:0] alpha;
      logic signed [SCORE_BITS-1:0] beta;
      logic signed [SCORE_BITS-1:0] new_score;
   } req_type;

   typedef struct packed {
      logic                         ok;
      logic                         score_valid;
      logic signed [SCORE_BITS-1:0] score;
   } result_type;

endpackage

// ===== rtl/transposition_table_probe_insert.sv =====
// Top level of the transposition table: entry RAM, clearing pass, request
// pipeline with write forwarding. Depends on tt_pkg, tt_ram and tt_eval.
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// request   req_op/slot/tag/occupied/depth/alpha/beta/    start high while busy low
//           req_new_score
// response  rsp_ok, rsp_score_valid, rsp_score            rsp_valid strobe, one cycle
// control   csr_index, csr_wdata                          csr_valid and csr_ready high
//
// One item is accepted per cycle while busy is low, and its result strobes once it
// has passed the evaluate stage and the response registers. The entry RAM is read in
// the accept cycle and written in the next, over the single RAM write port, and
// a forwarding register covers an item that reads the slot its predecessor
// writes in the same cycle. After reset the block sweeps the RAM to zero, one
// entry per cycle, and holds busy high until the sweep ends; control writes
// are taken throughout. The receiver cannot stall, so no item
// is ever held back once accepted.

module transposition_table_probe_insert #(
   parameter int TABLE_ENTRIES = tt_pkg::TT_TABLE_ENTRIES,
   parameter int TAG_BITS      = tt_pkg::TT_TAG_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_op,
   input  logic [tt_pkg::SLOT_BITS-1:0]            req_slot,
   input  logic [tt_pkg::TAG_PORT_BITS-1:0]        req_tag,
   input  logic [tt_pkg::OCC_BITS-1:0]             req_occupied,
   input  logic [tt_pkg::DEPTH_BITS-1:0]           req_depth,
   input  logic signed [tt_pkg::SCORE_BITS-1:0]    req_alpha,
   input  logic signed [tt_pkg::SCORE_BITS-1:0]    req_beta,
   input  logic signed [tt_pkg::SCORE_BITS-1:0]    req_new_score,
   output logic                                    rsp_valid,
   output logic                                    rsp_ok,
   output logic                                    rsp_score_valid,
   output logic signed [tt_pkg::SCORE_BITS-1:0]    rsp_score,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tt_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [tt_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   import tt_pkg::*;

   localparam int AddrBits  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int EntryBits = META_BITS + TAG_BITS;
   localparam bit Pow2      = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   // Control registers.
   cfg_type cfg_ff;

   // Clearing pass.
   logic                clr_active_ff;
   logic [AddrBits-1:0] clr_addr_ff;

   // Item in the evaluate stage.
   logic                s1_valid_ff;
   req_type             s1_req_ff;
   logic [AddrBits-1:0] s1_idx_ff;
   logic [TAG_BITS-1:0] s1_tag_ff;

   // Write forwarding for back-to-back items on one slot.
   logic                fwd_hit_ff;
   meta_type            fwd_meta_ff;
   logic [TAG_BITS-1:0] fwd_tag_ff;

   // Response registers.
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic                 accept;
   logic [AddrBits-1:0]  req_idx;
   logic [EntryBits-1:0] ram_rdata;
   logic                 ram_we;
   logic [AddrBits-1:0]  ram_waddr;
   logic [EntryBits-1:0] ram_wdata;
   meta_type             s_meta;
   logic [TAG_BITS-1:0]  s_tag;
   result_type           ev_result;
   logic                 ev_wr_en;
   meta_type             ev_wr_meta;
   logic                 wr_en;

   assign busy      = clr_active_ff;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // The slot wraps modulo the table size. A power-of-two table simply drops the
   // high slot bits; any other size reduces by shifted conditional subtraction.
   if (Pow2 || (TABLE_ENTRIES > (1 << SLOT_BITS))) begin : g_idx_direct
      assign req_idx = AddrBits'(req_slot);
   end else begin : g_idx_wrap
      logic [SLOT_BITS-1:0] wrap_rem;
      always_comb begin
         wrap_rem = req_slot;
         for (int k = SLOT_BITS - 1; k >= 0; k--) begin
            if ((longint'(TABLE_ENTRIES) << k) <= longint'(wrap_rem)) begin
               wrap_rem = wrap_rem - SLOT_BITS'(longint'(TABLE_ENTRIES) << k);
            end
         end
         req_idx = AddrBits'(wrap_rem);
      end
   end

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_base  <= SCORE_BASE_RESET;
         cfg_ff.yield_depth <= YIELD_DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCORE_BASE:  cfg_ff.score_base  <= csr_wdata[SCORE_BASE_BITS-1:0];
            CSR_YIELD_DEPTH: cfg_ff.yield_depth <= csr_wdata[DEPTH_BITS-1:0];
         endcase
      end
   end

   // Sweep every entry to zero after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AddrBits'(TABLE_ENTRIES - 1)) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + AddrBits'(1);
         end
      end
   end

   // The RAM is read at the incoming slot every cycle; the data is used only in
   // the cycle after an item was accepted.
   tt_ram #(
      .WIDTH (EntryBits),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (req_idx),
      .rdata (ram_rdata)
   );

   // Entry seen by the evaluate stage: forwarded if the previous item wrote
   // this slot in the very cycle it was read.
   assign s_meta = fwd_hit_ff ? fwd_meta_ff : meta_type'(ram_rdata[EntryBits-1 -: META_BITS]);
   assign s_tag  = fwd_hit_ff ? fwd_tag_ff : ram_rdata[TAG_BITS-1:0];

   tt_eval #(
      .TAG_BITS (TAG_BITS)
   ) u_eval (
      .cfg     (cfg_ff),
      .req     (s1_req_ff),
      .req_tag (s1_tag_ff),
      .s_meta  (s_meta),
      .s_tag   (s_tag),
      .result  (ev_result),
      .wr_en   (ev_wr_en),
      .wr_meta (ev_wr_meta)
   );

   assign wr_en     = s1_valid_ff && ev_wr_en;
   assign ram_we    = clr_active_ff || wr_en;
   assign ram_waddr = clr_active_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wdata = clr_active_ff ? '0 : {ev_wr_meta, s1_tag_ff};

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         fwd_hit_ff   <= accept && wr_en && (s1_idx_ff == req_idx);
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff.op        <= op_type'(req_op);
         s1_req_ff.occupied  <= req_occupied;
         s1_req_ff.depth     <= req_depth;
         s1_req_ff.alpha     <= req_alpha;
         s1_req_ff.beta      <= req_beta;
         s1_req_ff.new_score <= req_new_score;
         s1_idx_ff           <= req_idx;
         s1_tag_ff           <= req_tag[TAG_BITS-1:0];
      end
      fwd_meta_ff <= ev_wr_meta;
      fwd_tag_ff  <= s1_tag_ff;
      rsp_ff      <= ev_result;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_score_valid = rsp_ff.score_valid;
   assign rsp_score       = rsp_ff.score;

   // No item may be in flight while the clearing pass owns the write port.
   a_clear_idle : assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("item in flight during clearing pass");

   // Every item in the evaluate stage produces exactly one result next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid_ff)
      else $error("evaluated item produced no result");

   // A result without a decoded score carries a zero score.
   a_score_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_score_valid) |-> (rsp_score == '0))
      else $error("score nonzero while not valid");

   // Forwarded data is only ever consumed by a live item.
   a_fwd_live : assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("forwarding without an item");

   // A forwarded entry must follow a write in the previous cycle.
   a_fwd_after_write : assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> $past(wr_en))
      else $error("forwarding without a preceding write");

endmodule

// ===== rtl/tt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address collision; no dependencies.
`timescale 1ns / 1ps

module tt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tt_eval.sv =====
// Combinational evaluation of one request against the entry read for its slot:
// score decode/encode, probe acceptance, insert replacement. Depends on tt_pkg.
`timescale 1ns / 1ps

module tt_eval #(
   parameter int TAG_BITS = tt_pkg::TT_TAG_BITS
) (
   input  tt_pkg::cfg_type    cfg,
   input  tt_pkg::req_type    req,
   input  logic [TAG_BITS-1:0] req_tag,
   input  tt_pkg::meta_type   s_meta,
   input  logic [TAG_BITS-1:0] s_tag,
   output tt_pkg::result_type result,
   output logic               wr_en,
   output tt_pkg::meta_type   wr_meta
);

   import tt_pkg::*;

   // A stored code counts plies to the end; odd distances are wins.
   function automatic logic signed [SCORE_BITS-1:0] decode_score(
      input logic [CODE_BITS-1:0]       code,
      input logic [OCC_BITS-1:0]        occ,
      input logic [SCORE_BASE_BITS-1:0] max_s
   );
      logic [CODE_BITS-1:0] plies;
      logic signed [9:0]    mag;
      logic signed [9:0]    neg;
      plies = code - CODE_BITS'(1);
      mag  = $signed({3'b000, max_s}) - $signed({4'b0000, occ}) - $signed({4'b0000, plies});
      neg  = -mag;
      if (code == '0) begin
         return '0;
      end
      return plies[0] ? mag[SCORE_BITS-1:0] : neg[SCORE_BITS-1:0];
   endfunction

   function automatic logic [CODE_BITS-1:0] encode_score(
      input logic signed [SCORE_BITS-1:0] score,
      input logic [OCC_BITS-1:0]          occ,
      input logic [SCORE_BASE_BITS-1:0]   max_s
   );
      logic [SCORE_BITS-1:0] neg;
      logic [SCORE_BITS-1:0] mag;
      logic signed [9:0]     code;
      neg  = -score;
      mag  = score[SCORE_BITS-1] ? neg : score;
      code = $signed({3'b000, max_s}) - $signed({2'b00, mag})
             - $signed({4'b0000, occ}) + 10'sd1;
      if (score == '0) begin
         return '0;
      end
      if (code < 10'sd1) begin
         return CODE_BITS'(1);
      end
      if (code > $signed({4'b0000, CODE_MAX})) begin
         return CODE_MAX;
      end
      return code[CODE_BITS-1:0];
   endfunction

   logic signed [SCORE_BITS-1:0] dec;
   logic                         hit;
   logic                         usable;

   always_comb begin
      dec     = decode_score(s_meta.code, req.occupied, cfg.score_base);
      hit     = (s_meta.depth != '0) && (s_tag == req_tag);
      usable  = !((s_meta.depth < req.depth) && (dec == '0));
      result  = '0;
      wr_en   = 1'b0;
      wr_meta.code  = encode_score(req.new_score, req.occupied, cfg.score_base);
      wr_meta.depth = req.depth;
      if ($signed(req.new_score) <= $signed(req.alpha)) begin
         wr_meta.kind = KIND_UPPER;
      end else if ($signed(req.new_score) >= $signed(req.beta)) begin
         wr_meta.kind = KIND_LOWER;
      end else begin
         wr_meta.kind = KIND_EXACT;
      end

      unique case (req.op)
         OP_PROBE: begin
            if (hit) begin
               result.score_valid = 1'b1;
               result.score       = dec;
               if (usable) begin
                  case (s_meta.kind)
                     KIND_EXACT: result.ok = 1'b1;
                     KIND_LOWER: result.ok = $signed(dec) >= $signed(req.beta);
                     KIND_UPPER: result.ok = $signed(dec) <= $signed(req.alpha);
                     default:    result.ok = 1'b0;
                  endcase
               end
            end
         end
         OP_INSERT: begin
            if ((s_meta.depth == cfg.yield_depth) || (req.depth >= s_meta.depth)) begin
               wr_en     = 1'b1;
               result.ok = 1'b1;
            end
         end
         OP_READ: begin
            result.ok          = 1'b1;
            result.score_valid = 1'b1;
            result.score       = dec;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== verif/tt_result_checker.sv =====
// Scoreboard for the transposition table: keeps its own copy of the entry store
// and the two control registers, predicts each response and compares it. Uses tt_pkg.
`timescale 1ns / 1ps

module tt_result_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic [tt_pkg::SLOT_BITS-1:0]         req_slot,
   input  logic [tt_pkg::TAG_PORT_BITS-1:0]     req_tag,
   input  logic [tt_pkg::OCC_BITS-1:0]          req_occupied,
   input  logic [tt_pkg::DEPTH_BITS-1:0]        req_depth,
   input  logic signed [tt_pkg::SCORE_BITS-1:0] req_alpha,
   input  logic signed [tt_pkg::SCORE_BITS-1:0] req_beta,
   input  logic signed [tt_pkg::SCORE_BITS-1:0] req_new_score,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ok,
   input  logic                                 rsp_score_valid,
   input  logic signed [tt_pkg::SCORE_BITS-1:0] rsp_score,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tt_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output int unsigned                          outstanding,
   output int unsigned                          error_count
);
   import tt_pkg::*;

   logic [TAG_PORT_BITS-1:0]   tag_mirror [TT_TABLE_ENTRIES];
   meta_type                   meta_mirror [TT_TABLE_ENTRIES];
   logic [SCORE_BASE_BITS-1:0] score_base_q;
   logic [DEPTH_BITS-1:0]      yield_depth_q;
   result_type                 expected_q [$];

   // A code counts plies from the end; odd distances are wins for the side to move.
   function automatic int decode_score(input logic [CODE_BITS-1:0] code, input int occ);
      int plies;
      int mag;
      if (code == '0)
         return 0;
      plies = int'(code) - 1;
      mag   = int'(score_base_q) - (occ + plies);
      return (plies % 2 != 0) ? mag : -mag;
   endfunction

   function automatic logic [CODE_BITS-1:0] encode_score(input int value, input int occ);
      int code;
      if (value == 0)
         return '0;
      code = int'(score_base_q) - (value < 0 ? -value : value) - occ + 1;
      if (code < 1)
         code = 1;
      if (code > int'(CODE_MAX))
         code = int'(CODE_MAX);
      return code[CODE_BITS-1:0];
   endfunction

   // Works out the response of one request and applies its write to the mirror.
   function automatic result_type apply_request(
      input logic [1:0]           op,
      input logic [SLOT_BITS-1:0] slot,
      input logic [31:0]          tag,
      input int                   occ,
      input logic [DEPTH_BITS-1:0] depth,
      input int                   alpha,
      input int                   beta,
      input int                   new_score
   );
      meta_type   held;
      result_type res;
      int         decoded;
      kind_type   kind;
      held = meta_mirror[slot];
      res  = '0;
      if (op == OP_PROBE) begin
         if (held.depth != '0 && tag_mirror[slot] == tag) begin
            decoded         = decode_score(held.code, occ);
            res.score_valid = 1'b1;
            res.score       = decoded[SCORE_BITS-1:0];
            // A shallower entry is still usable when it holds a proven result.
            if (!(held.depth < depth && decoded == 0)) begin
               case (held.kind)
                  KIND_EXACT: res.ok = 1'b1;
                  KIND_LOWER: res.ok = (decoded >= beta);
                  KIND_UPPER: res.ok = (decoded <= alpha);
                  default:    res.ok = 1'b0;
               endcase
            end
         end
      end else if (op == OP_INSERT) begin
         if (held.depth == yield_depth_q || depth >= held.depth) begin
            if (new_score <= alpha)
               kind = KIND_UPPER;
            else if (new_score >= beta)
               kind = KIND_LOWER;
            else
               kind = KIND_EXACT;
            tag_mirror[slot]  = tag;
            meta_mirror[slot] = '{code: encode_score(new_score, occ), kind: kind, depth: depth};
            res.ok = 1'b1;
         end
      end else if (op == OP_READ) begin
         decoded         = decode_score(held.code, occ);
         res.score       = decoded[SCORE_BITS-1:0];
         res.score_valid = 1'b1;
         res.ok          = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int i = 0; i < TT_TABLE_ENTRIES; i++) begin
            tag_mirror[i]  = '0;
            meta_mirror[i] = '0;
         end
         score_base_q  = SCORE_BASE_RESET;
         yield_depth_q = YIELD_DEPTH_RESET;
         expected_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               $error("response with nothing outstanding: ok=%0b score_valid=%0b score=%0d",
                      rsp_ok, rsp_score_valid, rsp_score);
               error_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok: expected %0b, got %0b", want.ok, rsp_ok);
                  error_count++;
               end
               if (rsp_score_valid !== want.score_valid) begin
                  $error("score_valid: expected %0b, got %0b", want.score_valid, rsp_score_valid);
                  error_count++;
               end
               if (rsp_score !== want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_score);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SCORE_BASE)
               score_base_q = csr_wdata[SCORE_BASE_BITS-1:0];
            else
               yield_depth_q = csr_wdata[DEPTH_BITS-1:0];
         end
         if (start && !busy)
            expected_q.push_back(apply_request(req_op, req_slot, req_tag, int'(req_occupied),
                                               req_depth, int'(req_alpha), int'(req_beta),
                                               int'(req_new_score)));
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== verif/transposition_table_probe_insert_test.sv =====
// Top of the transposition table testbench: clock, reset, request and control
// stimulus, watchdog and verdict. Uses tt_pkg, tt_result_checker and the block.
`timescale 1ns / 1ps

module transposition_table_probe_insert_test;
   import tt_pkg::*;

   // The op field has one code that the block does not define; it must do nothing.
   localparam logic [1:0]  OP_UNUSED       = 2'd3;
   localparam int          RANDOM_PHASES   = 6;
   localparam int          ITEMS_PER_PHASE = 330;
   localparam int          POOL_SIZE       = 16;
   localparam int          DRAIN_CYCLES    = 8;
   // The clearing pass after reset keeps busy high with no traffic at all while
   // it sweeps the table; the limit leaves a wide margin over that.
   localparam int unsigned STALL_LIMIT     = 20000;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          start         = 1'b0;
   logic                          busy;
   logic [1:0]                    req_op        = '0;
   logic [SLOT_BITS-1:0]          req_slot      = '0;
   logic [TAG_PORT_BITS-1:0]      req_tag       = '0;
   logic [OCC_BITS-1:0]           req_occupied  = '0;
   logic [DEPTH_BITS-1:0]         req_depth     = '0;
   logic signed [SCORE_BITS-1:0]  req_alpha     = '0;
   logic signed [SCORE_BITS-1:0]  req_beta      = '0;
   logic signed [SCORE_BITS-1:0]  req_new_score = '0;
   logic                          rsp_valid;
   logic                          rsp_ok;
   logic                          rsp_score_valid;
   logic signed [SCORE_BITS-1:0]  rsp_score;
   logic                          csr_valid     = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata     = '0;

   int unsigned outstanding;
   int unsigned error_count;
   int unsigned quiet_cycles = 0;

   // Percentage of cycles in which the request side idles.
   int unsigned gap_pct = 0;
   // The book depth currently programmed, so that random depths can hit it.
   int          yield_depth_now = int'(YIELD_DEPTH_RESET);

   // Random traffic is concentrated on a few slots with two competing tags each,
   // so that probes land on entries written a moment earlier and replacement
   // decisions actually compare stored and new depths.
   int          slot_pool [POOL_SIZE];
   logic [31:0] tag_pool  [POOL_SIZE][2];

   always #5 clock = ~clock;

   transposition_table_probe_insert u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_tag         (req_tag),
      .req_occupied    (req_occupied),
      .req_depth       (req_depth),
      .req_alpha       (req_alpha),
      .req_beta        (req_beta),
      .req_new_score   (req_new_score),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_score_valid (rsp_score_valid),
      .rsp_score       (rsp_score),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   tt_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_slot        (req_slot),
      .req_tag         (req_tag),
      .req_occupied    (req_occupied),
      .req_depth       (req_depth),
      .req_alpha       (req_alpha),
      .req_beta        (req_beta),
      .req_new_score   (req_new_score),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_score_valid (rsp_score_valid),
      .rsp_score       (rsp_score),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .outstanding     (outstanding),
      .error_count     (error_count)
   );

   // The watchdog restarts on any transfer: an accepted item, a response or a
   // register write. A long stretch without any of them means the block hung.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Every task is entered and left at a falling edge. An item is held on the
   // ports until a rising edge sees busy low. When no gap is drawn, start simply
   // stays high and the next item follows in the very next cycle.
   task automatic send_item(input logic [1:0] op, input int slot, input logic [31:0] tag,
                            input int occ, input int depth, input int alpha,
                            input int beta, input int new_score);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_op        <= op;
      req_slot      <= slot[SLOT_BITS-1:0];
      req_tag       <= tag;
      req_occupied  <= occ[OCC_BITS-1:0];
      req_depth     <= depth[DEPTH_BITS-1:0];
      req_alpha     <= alpha[SCORE_BITS-1:0];
      req_beta      <= beta[SCORE_BITS-1:0];
      req_new_score <= new_score[SCORE_BITS-1:0];
      start         <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drops start and holds off until the checker has seen every response.
   task automatic wait_drained();
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input int value);
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Scores favor zero (the undecided result) and the range where decoded
   // scores fall, with a share drawn over the whole 8-bit range.
   function automatic int rand_score();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15)
         return 0;
      if (pick < 40)
         return int'($urandom_range(255)) - 128;
      return int'($urandom_range(120)) - 60;
   endfunction

   // Mostly small depths so that replacement goes both ways; zero, the maximum
   // and the book depth show up on purpose.
   function automatic int rand_depth();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         return 0;
      if (pick < 20)
         return 63;
      if (pick < 30)
         return yield_depth_now;
      return $urandom_range(12, 1);
   endfunction

   task automatic fill_pools();
      for (int i = 0; i < POOL_SIZE; i++) begin
         slot_pool[i]   = $urandom_range(4095);
         tag_pool[i][0] = $urandom;
         tag_pool[i][1] = $urandom;
      end
      // Keep the two end slots of the table in play.
      slot_pool[0]             = 0;
      slot_pool[POOL_SIZE - 1] = 4095;
   endtask

   task automatic send_random_item();
      int          pick;
      int          lane;
      int          slot;
      int          occ;
      int          alpha;
      int          beta;
      int          swap;
      logic [31:0] tag;
      logic [1:0]  op;
      pick = $urandom_range(99);
      if (pick < 40)
         op = OP_PROBE;
      else if (pick < 78)
         op = OP_INSERT;
      else if (pick < 93)
         op = OP_READ;
      else
         op = OP_UNUSED;
      // A small share of the traffic goes anywhere in the table with any tag.
      if ($urandom_range(99) < 8) begin
         slot = $urandom_range(4095);
         tag  = $urandom;
      end else begin
         lane = $urandom_range(POOL_SIZE - 1);
         slot = slot_pool[lane];
         tag  = tag_pool[lane][$urandom_range(1)];
      end
      occ   = ($urandom_range(99) < 85) ? $urandom_range(42) : $urandom_range(63);
      alpha = rand_score();
      beta  = rand_score();
      // Mostly a proper window, sometimes an inverted one.
      if (alpha > beta && $urandom_range(99) < 70) begin
         swap  = alpha;
         alpha = beta;
         beta  = swap;
      end
      send_item(op, slot, tag, occ, rand_depth(), alpha, beta, rand_score());
   endtask

   initial begin
      int score_base_val;
      int yield_depth_val;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items under the reset settings. The first one waits out the
      // clearing pass, since busy stays high until the table is swept.
      gap_pct = 0;
      // An empty slot reads as zero, and a probe of it misses.
      send_item(OP_READ,  0, 32'h0, 0, 0, 0, 0, 0);
      send_item(OP_PROBE, 0, 32'h0, 0, 0, 0, 0, 0);
      // Exact entry, then a hit and a tag miss on it.
      send_item(OP_INSERT, 0, 32'h0, 0, 5, -10, 10, 5);
      send_item(OP_PROBE,  0, 32'h0, 0, 3, -10, 10, 0);
      send_item(OP_PROBE,  0, 32'hFFFF_FFFF, 0, 3, -10, 10, 0);
      // Upper bound at the top slot with most fields at an extreme; the code
      // saturates at its low end.
      send_item(OP_INSERT, 4095, 32'hFFFF_FFFF, 42, 63, -128, 127, -128);
      send_item(OP_PROBE,  4095, 32'hFFFF_FFFF, 42, 63, 127, 127, 0);
      send_item(OP_PROBE,  4095, 32'hFFFF_FFFF, 42, 63, -128, -128, 0);
      // The stored depth equals the book depth, so a shallower insert still
      // replaces it; this one becomes a lower bound.
      send_item(OP_INSERT, 4095, 32'hFFFF_FFFF, 42, 1, -128, 127, 127);
      send_item(OP_PROBE,  4095, 32'hFFFF_FFFF, 42, 1, 0, -128, 0);
      // A depth-zero insert does not replace a deeper entry.
      send_item(OP_INSERT, 4095, 32'h1234_5678, 0, 0, 0, 0, 0);
      // A zero score from a shallower entry is a hit but not usable.
      send_item(OP_INSERT, 1, 32'h5, 20, 10, -5, 5, 0);
      send_item(OP_PROBE,  1, 32'h5, 20, 20, -5, 5, 0);
      send_item(OP_PROBE,  1, 32'h5, 20, 10, -5, 5, 0);
      // A shallower insert yields to the deeper entry.
      send_item(OP_INSERT, 1, 32'h5, 20, 4, -5, 5, 9);
      // Written with depth zero: the slot counts as empty for a probe, while
      // a read still decodes whatever code it holds.
      send_item(OP_INSERT, 2, 32'h7, 3, 0, -40, 40, 30);
      send_item(OP_PROBE,  2, 32'h7, 3, 0, -40, 40, 0);
      send_item(OP_READ,   2, 32'h0, 3, 0, 0, 0, 0);
      // The undefined op leaves the table alone and answers with zeros.
      send_item(OP_UNUSED, 0, 32'hFFFF_FFFF, 63, 63, 127, 127, 127);
      // Occupied count beyond the board size, lower bound, then a probe.
      send_item(OP_INSERT, 3, 32'h9, 63, 8, 0, 10, 20);
      send_item(OP_PROBE,  3, 32'h9, 10, 2, 0, -128, 0);
      // A proven score from a shallower entry is usable; upper bound check.
      send_item(OP_INSERT, 4, 32'h1, 0, 2, 0, 5, -1);
      send_item(OP_PROBE,  4, 32'h1, 0, 9, 0, 5, 0);
      send_item(OP_READ,   4, 32'h0, 30, 0, 0, 0, 0);
      wait_drained();

      // Random phases, each under its own register settings. Registers are
      // written only with nothing outstanding, which also makes the request
      // side pause until every response is in.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin score_base_val = 43;  yield_depth_val = 63; end
            1: begin score_base_val = 127; yield_depth_val = 0;  end
            2: begin score_base_val = 0;   yield_depth_val = 5;  end
            3: begin score_base_val = 64;  yield_depth_val = 63; end
            4: begin
               score_base_val  = $urandom_range(127);
               yield_depth_val = $urandom_range(63);
            end
            default: begin score_base_val = 127; yield_depth_val = 1; end
         endcase
         write_reg(CSR_SCORE_BASE, score_base_val);
         // The top data bit has no meaning for the book depth; toggle it anyway.
         write_reg(CSR_YIELD_DEPTH, yield_depth_val + 64 * int'($urandom_range(1)));
         yield_depth_now = yield_depth_val;
         // Idle pattern on the request side: light gaps, heavy gaps, then none.
         gap_pct = (phase < 2) ? 19 : (phase < 4) ? 50 : 0;
         fill_pools();
         repeat (ITEMS_PER_PHASE)
            send_random_item();
         wait_drained();
      end

      // Each result passes through the evaluate stage and the response registers; idling on
      // after the drain means that a stray response would still be caught.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
